[rtl/tgad_pkg.sv]
// Shared types and constants for the TGA pixel stream decoder.
package tgad_pkg;

	// Register map, word index of paddr
	localparam int unsigned RegIdxW = 2;
	localparam int unsigned AddrW   = RegIdxW + 2;

	localparam logic [RegIdxW-1:0] REG_COMPRESSED   = 2'd0;
	localparam logic [RegIdxW-1:0] REG_PIXEL_DEPTH  = 2'd1;
	localparam logic [RegIdxW-1:0] REG_IMAGE_WIDTH  = 2'd2;
	localparam logic [RegIdxW-1:0] REG_IMAGE_HEIGHT = 2'd3;

	// Supported pixel depths in bits
	localparam logic [7:0] DEPTH_16 = 8'd16;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	localparam logic [7:0] DEPTH_RESET = DEPTH_24;

	// Packet header split point and run bias
	localparam logic [7:0] RUN_FLAG = 8'd128;
	localparam logic [7:0] RUN_BIAS = 8'd127;

	// RLE packet parser state
	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_RAW    = 2'd1,
		MODE_RUN    = 2'd2
	} mode_t;

	// Configuration seen by the decoder
	typedef struct packed {
		logic        compressed;
		logic [7:0]  pixel_depth;
		logic [31:0] total;     // width * height, registered
		logic        wr;        // any register write this cycle
	} cfg_t;

	// One decoded result
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       has_alpha;
		logic [7:0] repeat_res;
		logic       last;
		logic       bad_depth;
	} pix_t;

endpackage

[rtl/tga_pixel_stream_decoder.sv]
// Top level of the TGA pixel stream decoder: config port, decode stage, result register.
// Takes TGA pixel-data bytes, one per beat, and returns decoded RGB(A) pixels (16-bit 5-5-5,
// 24-bit BGR or 32-bit BGRA; RLE packets when compressed is set, 24 and 32 bits only, with a
// run returned once and its count in repeat_res). Throughput is one byte per clock while the
// input does not stall: each byte passes an input register and the decode logic into the
// result register, which drives the outputs. Bytes that finish no pixel keep flowing while a
// result waits; the input stalls only when a finished pixel or error beat stands behind a
// result that has not been taken. Header bytes and the leading bytes of a pixel yield no
// beat. Registers sit at byte addresses 0 (compressed), 4 (pixel_depth), 8 (image_width) and
// 12 (image_height); any write abandons the frame in progress. The pixel count width*height
// is registered from width and height. Unsupported depths give one bad_depth beat per byte.
module tga_pixel_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tgad_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// byte input
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	// pixel output
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic [7:0]                  alpha,
	output logic                        has_alpha,
	output logic [7:0]                  repeat_res,
	output logic                        last,
	output logic                        bad_depth
);
	import tgad_pkg::*;

	cfg_t cfg;
	pix_t res;
	pix_t out_q;
	logic res_valid;
	logic res_take;
	logic out_valid_q;

	tgad_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgad_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register loads when empty or being drained
	assign res_take = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = out_q.red;
	assign green      = out_q.green;
	assign blue       = out_q.blue;
	assign alpha      = out_q.alpha;
	assign has_alpha  = out_q.has_alpha;
	assign repeat_res = out_q.repeat_res;
	assign last       = out_q.last;
	assign bad_depth  = out_q.bad_depth;

`ifndef SYNTHESIS
	// error beats carry no pixel and never end an image
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_depth |-> red == 8'd0 && green == 8'd0 && blue == 8'd0 &&
			alpha == 8'd0 && !has_alpha && repeat_res == 8'd1 && !last)
		else $error("bad_depth beat with nonzero pixel fields");

	// every beat carries a nonzero repeat count
	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_res != 8'd0)
		else $error("zero repeat count");

	// alpha is zero unless the depth carries it
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_alpha |-> alpha == 8'd0)
		else $error("alpha without has_alpha");

	// a result waiting in the input stage loads as soon as the output drains
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && res_valid |=> out_valid)
		else $error("result lost at output register");
`endif

endmodule

[rtl/tgad_cfg_regs.sv]
// APB configuration registers and the registered pixel count of the image.
module tgad_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tgad_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output tgad_pkg::cfg_t              cfg
);
	import tgad_pkg::*;

	logic                compressed_q;
	logic [7:0]          pixel_depth_q;
	logic [15:0]         image_width_q;
	logic [15:0]         image_height_q;
	logic [31:0]         total_q;
	logic                wr;
	logic [RegIdxW-1:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[AddrW-1:2];
	assign wr     = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q   <= 1'b0;
			pixel_depth_q  <= DEPTH_RESET;
			image_width_q  <= 16'd0;
			image_height_q <= 16'd0;
		end else if (wr) begin
			unique case (idx)
				REG_COMPRESSED:   compressed_q   <= pwdata[0];
				REG_PIXEL_DEPTH:  pixel_depth_q  <= pwdata[7:0];
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[15:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// pixel count, registered from the width and height registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 32'd0;
		end else begin
			total_q <= {16'd0, image_width_q} * {16'd0, image_height_q};
		end
	end

	// read mux
	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			REG_COMPRESSED:   prdata = {31'd0, compressed_q};
			REG_PIXEL_DEPTH:  prdata = {24'd0, pixel_depth_q};
			REG_IMAGE_WIDTH:  prdata = {16'd0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign cfg.compressed  = compressed_q;
	assign cfg.pixel_depth = pixel_depth_q;
	assign cfg.total       = total_q;
	assign cfg.wr          = wr;

endmodule

[rtl/tgad_decode.sv]
// Input stage register, packet/pixel assembly state and per-byte decode.
module tgad_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  tgad_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            res_take,   // result register can load this cycle
	output logic            res_valid,
	output tgad_pkg::pix_t  res
);
	import tgad_pkg::*;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// decode state
	logic        frame_active_q;
	mode_t       packet_mode_q;
	logic [7:0]  packet_left_q;
	logic [1:0]  byte_phase_q;
	logic [23:0] pixel_bytes_q;
	logic [31:0] pixels_left_q;

	// next state
	logic        frame_active_d;
	mode_t       packet_mode_d;
	logic [7:0]  packet_left_d;
	logic [1:0]  byte_phase_d;
	logic [23:0] pixel_bytes_d;
	logic [31:0] pixels_left_d;

	// effective state after a possible frame start
	mode_t       mode_e;
	logic [7:0]  left_e;
	logic [1:0]  phase_e;
	logic [23:0] bytes_e;
	logic [31:0] pl_e;

	logic        depth_ok;
	logic        is16;
	logic        is24;
	logic        is32;
	logic [2:0]  nbytes;
	logic [7:0]  count;
	logic [7:0]  rep;
	logic [7:0]  left_after;
	logic [31:0] pl_after;
	logic [15:0] word16;
	logic        produce;
	logic        fire_s1;

	assign is16     = (cfg.pixel_depth == DEPTH_16);
	assign is24     = (cfg.pixel_depth == DEPTH_24);
	assign is32     = (cfg.pixel_depth == DEPTH_32);
	assign depth_ok = is24 | is32 | (is16 & ~cfg.compressed);
	assign nbytes   = cfg.pixel_depth[5:3];

	// stage advances when its result can be taken or it has none
	assign fire_s1  = valid_s1 & (res_take | ~produce);
	assign in_ready = ~valid_s1 | res_take | ~produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// per-byte decode
	always_comb begin
		frame_active_d = frame_active_q;
		packet_mode_d  = packet_mode_q;
		packet_left_d  = packet_left_q;
		byte_phase_d   = byte_phase_q;
		pixel_bytes_d  = pixel_bytes_q;
		pixels_left_d  = pixels_left_q;
		produce        = 1'b0;
		res            = '0;
		res.repeat_res = 8'd1;
		count          = 8'd0;
		rep            = 8'd1;
		left_after     = 8'd0;
		pl_after       = 32'd0;
		word16         = 16'd0;

		// a byte while idle opens a frame with fresh assembly state
		if (frame_active_q) begin
			mode_e  = packet_mode_q;
			left_e  = packet_left_q;
			phase_e = byte_phase_q;
			bytes_e = pixel_bytes_q;
			pl_e    = pixels_left_q;
		end else begin
			mode_e  = MODE_HEADER;
			left_e  = 8'd0;
			phase_e = 2'd0;
			bytes_e = 24'd0;
			pl_e    = cfg.total;
		end

		if (!depth_ok) begin
			// unsupported depth: error beat, drop the frame
			produce        = 1'b1;
			res.bad_depth  = 1'b1;
			frame_active_d = 1'b0;
			packet_mode_d  = MODE_HEADER;
			packet_left_d  = 8'd0;
			byte_phase_d   = 2'd0;
			pixel_bytes_d  = 24'd0;
			pixels_left_d  = 32'd0;
		end else if (!frame_active_q && cfg.total == 32'd0) begin
			// empty image: byte dropped, stay idle
			produce = 1'b0;
		end else if (cfg.compressed && mode_e == MODE_HEADER) begin
			// packet header, count clamped to the pixels left
			if (byte_s1 < RUN_FLAG) begin
				count = byte_s1 + 8'd1;
			end else begin
				count = byte_s1 - RUN_BIAS;
			end
			if ({24'd0, count} > pl_e) begin
				count = pl_e[7:0];
			end
			frame_active_d = 1'b1;
			packet_left_d  = count;
			packet_mode_d  = (byte_s1 < RUN_FLAG) ? MODE_RAW : MODE_RUN;
			byte_phase_d   = phase_e;
			pixel_bytes_d  = bytes_e;
			pixels_left_d  = pl_e;
		end else if ({1'b0, phase_e} + 3'd1 < nbytes) begin
			// gather the low bytes of a pixel
			frame_active_d = 1'b1;
			packet_mode_d  = mode_e;
			packet_left_d  = left_e;
			byte_phase_d   = phase_e + 2'd1;
			pixel_bytes_d  = bytes_e | ({16'd0, byte_s1} << {phase_e, 3'd0});
			pixels_left_d  = pl_e;
		end else begin
			// final byte: emit the pixel
			produce = 1'b1;
			if (is16) begin
				word16    = {byte_s1, bytes_e[7:0]};
				res.blue  = {word16[4:0], 3'd0};
				res.green = {word16[9:5], 3'd0};
				res.red   = {word16[14:10], 3'd0};
			end else begin
				res.blue  = bytes_e[7:0];
				res.green = bytes_e[15:8];
				res.red   = is24 ? byte_s1 : bytes_e[23:16];
				res.alpha = is32 ? byte_s1 : 8'd0;
			end
			res.has_alpha = is32;

			left_after = left_e;
			rep        = 8'd1;
			if (cfg.compressed) begin
				if (mode_e == MODE_RUN) begin
					rep        = left_e;
					left_after = 8'd0;
				end else begin
					left_after = left_e - 8'd1;
				end
			end
			pl_after       = pl_e - {24'd0, rep};
			res.repeat_res = rep;
			res.last       = (pl_after == 32'd0);

			if (res.last) begin
				frame_active_d = 1'b0;
				packet_mode_d  = MODE_HEADER;
				packet_left_d  = 8'd0;
				pixels_left_d  = 32'd0;
			end else begin
				frame_active_d = 1'b1;
				packet_mode_d  = (cfg.compressed && left_after == 8'd0) ? MODE_HEADER
				                                                     : mode_e;
				packet_left_d  = left_after;
				pixels_left_d  = pl_after;
			end
			byte_phase_d  = 2'd0;
			pixel_bytes_d = 24'd0;
		end
	end

	assign res_valid = valid_s1 & produce;

	// decode state registers; a register write abandons the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q <= 1'b0;
			packet_mode_q  <= MODE_HEADER;
			packet_left_q  <= 8'd0;
			byte_phase_q   <= 2'd0;
			pixel_bytes_q  <= 24'd0;
			pixels_left_q  <= 32'd0;
		end else if (cfg.wr) begin
			frame_active_q <= 1'b0;
			packet_mode_q  <= MODE_HEADER;
			packet_left_q  <= 8'd0;
			byte_phase_q   <= 2'd0;
			pixel_bytes_q  <= 24'd0;
			pixels_left_q  <= 32'd0;
		end else if (fire_s1) begin
			frame_active_q <= frame_active_d;
			packet_mode_q  <= packet_mode_d;
			packet_left_q  <= packet_left_d;
			byte_phase_q   <= byte_phase_d;
			pixel_bytes_q  <= pixel_bytes_d;
			pixels_left_q  <= pixels_left_d;
		end
	end

endmodule
